// ----- hdl/imu_bc_pkg.sv -----
// Shared types and constants for the IMU bias calibrate/subtract block.
`timescale 1ns / 1ps

package imu_bc_pkg;

    localparam int SAMPLES_PER_CAL = 200;

    // Sample counter covers 0 .. SAMPLES_PER_CAL-1
    localparam int CNT_W     = $clog2(SAMPLES_PER_CAL);
    // Largest sum magnitude is (N-1)*65535 < 2**(CNT_W+16)
    localparam int MAG_W     = CNT_W + 16;
    localparam int SUM_W     = MAG_W + 1;
    // Exact reciprocal: floor(a/N) == (a*RECIP) >> DIV_SHIFT for a < 2**MAG_W
    localparam int DIV_SHIFT = MAG_W + CNT_W;
    localparam int RECIP_W   = MAG_W + 2;
    localparam int PROD_W    = MAG_W + RECIP_W;

    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SHIFT) + 64'(SAMPLES_PER_CAL) - 64'd1) / 64'(SAMPLES_PER_CAL);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(SAMPLES_PER_CAL - 1);
    localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(1);

    localparam logic [14:0] ACCEL_ONE_G_RST = 15'd8196;

    localparam int NUM_AXES = 6;
    localparam int NUM_SUMS = 3;

    // Request codes carried in the mode field
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_ACCEL  = 2'd1;
    localparam logic [1:0] MODE_GYRO   = 2'd2;
    localparam logic [1:0] MODE_BOTH   = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] accel_x_corr;
        logic signed [15:0] accel_y_corr;
        logic signed [15:0] accel_z_corr;
        logic signed [15:0] gyro_x_corr;
        logic signed [15:0] gyro_y_corr;
        logic signed [15:0] gyro_z_corr;
        logic               wrap_flag;
        logic               gyro_cal_done;
        logic               accel_cal_done;
        logic               cal_busy;
    } t_out_item;

    // Index 0..2 accel X/Y/Z, 3..5 gyro X/Y/Z
    typedef logic [NUM_AXES-1:0][15:0] t_axes;

    typedef struct packed {
        logic add;
        logic clear;
    } t_lane_ctl;

    typedef struct packed {
        logic zero;
        logic load;
    } t_off_ctl;

    typedef struct packed {
        logic zero_gyro;
        logic zero_accel;
        logic load_gyro;
        logic load_accel;
        logic gyro_done;
        logic accel_done;
        logic busy;
    } t_item_flags;

    typedef struct packed {
        t_lane_ctl   lane;
        logic        use_accel;
        t_item_flags flags;
    } t_cal_ctl;

    typedef struct packed {
        t_axes       raw;
        t_item_flags flags;
    } t_stage;

endpackage

// ----- hdl/imu_bc_in_if.sv -----
// Input channel: raw sample item with valid/ready.
`timescale 1ns / 1ps

interface imu_bc_in_if;
    logic                 valid;
    logic                 ready;
    imu_bc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/imu_bc_out_if.sv -----
// Output channel: corrected sample and calibration status with valid/ready.
`timescale 1ns / 1ps

interface imu_bc_out_if;
    logic                  valid;
    logic                  ready;
    imu_bc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/imu_bias_calibrate_subtract_top.sv -----
// Top level: IMU bias subtraction with on-request gyro/accel offset calibration.
`timescale 1ns / 1ps

// Channel     Dir  Handshake         Payload
// i_in        in   valid/ready       mode, accel_x/y/z, gyro_x/y/z
// o_out       out  valid/ready       six corrected axes, wrap, done flags, busy
// i_cfg_*     in   write enable      accel_one_g (15 bits)
//
// One item per cycle while the output is not stalled. Three register stages: accumulate,
// the reciprocal multiply that forms the mean, and the offset subtract into the output
// register; each stage holds its item on a stall and takes a new one whenever the stage
// ahead moves, so bubbles collapse.
// Synchronous active-low reset clears offsets, sums, counter, flags and valids;
// accel_one_g returns to 8196.

module imu_bias_calibrate_subtract_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    imu_bc_in_if.sink           i_in,
    imu_bc_out_if.source        o_out,
    input  logic                i_cfg_wr_en,
    input  logic [14:0]         i_cfg_wr_data
);

    logic [14:0]          r_accel_one_g;
    logic                 r_v1;
    logic                 r_v2;
    logic                 r_ov;
    imu_bc_pkg::t_stage   r_p1;
    imu_bc_pkg::t_stage   r_p2;
    imu_bc_pkg::t_item_flags r_oflags;

    logic                 out_free;
    logic                 s2_free;
    logic                 s1_free;
    logic                 accept;
    logic                 ld2;
    logic                 ld3;
    imu_bc_pkg::t_cal_ctl cal_ctl;
    imu_bc_pkg::t_axes    n_raw;
    logic signed [16:0]   lane_val [imu_bc_pkg::NUM_SUMS];
    logic [15:0]          lane_mean [imu_bc_pkg::NUM_SUMS];
    logic [15:0]          corr [imu_bc_pkg::NUM_AXES];
    logic [imu_bc_pkg::NUM_AXES-1:0] wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_one_g <= imu_bc_pkg::ACCEL_ONE_G_RST;
        end else if (i_cfg_wr_en) begin
            r_accel_one_g <= i_cfg_wr_data;
        end
    end

    // stage handshake
    assign out_free   = !r_ov || o_out.ready;
    assign s2_free    = !r_v2 || out_free;
    assign s1_free    = !r_v1 || s2_free;
    assign i_in.ready = s1_free;
    assign accept     = i_in.valid && s1_free;
    assign ld2        = r_v1 && s2_free;
    assign ld3        = r_v2 && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_in.valid;
            end
            if (s2_free) begin
                r_v2 <= r_v1;
            end
            if (out_free) begin
                r_ov <= r_v2;
            end
        end
    end

    imu_bc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (i_in.data.mode),
        .o_ctl    (cal_ctl)
    );

    assign n_raw = {i_in.data.gyro_z, i_in.data.gyro_y, i_in.data.gyro_x,
                    i_in.data.accel_z, i_in.data.accel_y, i_in.data.accel_x};

    // Sums run on raw values: the calibrating sensor's offsets are zero by then.
    always_comb begin
        for (int k = 0; k < imu_bc_pkg::NUM_SUMS; k++) begin
            if (!cal_ctl.use_accel) begin
                lane_val[k] = {n_raw[k + 3][15], n_raw[k + 3]};
            end else if (k == imu_bc_pkg::NUM_SUMS - 1) begin
                lane_val[k] = {n_raw[k][15], n_raw[k]} - {2'b00, r_accel_one_g};
            end else begin
                lane_val[k] = {n_raw[k][15], n_raw[k]};
            end
        end
    end

    generate
        for (genvar k = 0; k < imu_bc_pkg::NUM_SUMS; k++) begin : g_sum
            imu_bc_sum_lane u_sum (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ld_in  (accept),
                .i_ld_mid (ld2),
                .i_ctl    (cal_ctl.lane),
                .i_val    (lane_val[k]),
                .o_mean   (lane_mean[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p1.raw   <= n_raw;
            r_p1.flags <= cal_ctl.flags;
        end
        if (ld2) begin
            r_p2 <= r_p1;
        end
        if (ld3) begin
            r_oflags <= r_p2.flags;
        end
    end

    generate
        for (genvar i = 0; i < imu_bc_pkg::NUM_AXES; i++) begin : g_corr
            imu_bc_pkg::t_off_ctl off_ctl;
            if (i < imu_bc_pkg::NUM_SUMS) begin : g_accel
                assign off_ctl.zero = r_p2.flags.zero_accel;
                assign off_ctl.load = r_p2.flags.load_accel;
            end else begin : g_gyro
                assign off_ctl.zero = r_p2.flags.zero_gyro;
                assign off_ctl.load = r_p2.flags.load_gyro;
            end
            imu_bc_corr_lane u_corr (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ld    (ld3),
                .i_raw   (r_p2.raw[i]),
                .i_off   (off_ctl),
                .i_mean  (lane_mean[i % imu_bc_pkg::NUM_SUMS]),
                .o_corr  (corr[i]),
                .o_wrap  (wrap[i])
            );
        end
    endgenerate

    // merge: any lane wrap flags the item
    assign o_out.valid               = r_ov;
    assign o_out.data.accel_x_corr   = corr[0];
    assign o_out.data.accel_y_corr   = corr[1];
    assign o_out.data.accel_z_corr   = corr[2];
    assign o_out.data.gyro_x_corr    = corr[3];
    assign o_out.data.gyro_y_corr    = corr[4];
    assign o_out.data.gyro_z_corr    = corr[5];
    assign o_out.data.wrap_flag      = |wrap;
    assign o_out.data.gyro_cal_done  = r_oflags.gyro_done;
    assign o_out.data.accel_cal_done = r_oflags.accel_done;
    assign o_out.data.cal_busy       = r_oflags.busy;

endmodule

// ----- hdl/imu_bc_ctrl.sv -----
// Calibration sequencer: request handling, sample counter, gyro-then-accel chaining.
`timescale 1ns / 1ps

module imu_bc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_mode,
    output imu_bc_pkg::t_cal_ctl o_ctl
);

    logic                         r_gyro_act;
    logic                         r_accel_act;
    logic [imu_bc_pkg::CNT_W-1:0] r_cnt;
    logic                         n_gyro_act;
    logic                         n_accel_act;
    logic [imu_bc_pkg::CNT_W-1:0] n_cnt;

    always_comb begin
        o_ctl       = '0;
        n_gyro_act  = r_gyro_act;
        n_accel_act = r_accel_act;
        n_cnt       = r_cnt;

        // requests only start from idle
        if (!r_gyro_act && !r_accel_act && i_mode != imu_bc_pkg::MODE_SAMPLE) begin
            if (i_mode == imu_bc_pkg::MODE_ACCEL) begin
                n_accel_act = 1'b1;
            end else begin
                n_gyro_act = 1'b1;
            end
            n_cnt = '0;
        end

        if (n_gyro_act) begin
            if (n_cnt == '0) begin
                o_ctl.flags.zero_gyro = 1'b1;
                o_ctl.lane.clear      = 1'b1;
                n_cnt                 = imu_bc_pkg::CNT_FIRST;
            end else begin
                o_ctl.lane.add = 1'b1;
                if (n_cnt == imu_bc_pkg::CNT_LAST) begin
                    o_ctl.flags.load_gyro = 1'b1;
                    o_ctl.flags.gyro_done = 1'b1;
                    n_gyro_act            = 1'b0;
                    n_accel_act           = 1'b1;
                    n_cnt                 = '0;
                end else begin
                    n_cnt = n_cnt + imu_bc_pkg::CNT_FIRST;
                end
            end
        end

        // same item that ends the gyro run is the discarded first accel item
        if (n_accel_act) begin
            if (n_cnt == '0) begin
                o_ctl.flags.zero_accel = 1'b1;
                o_ctl.lane.clear       = 1'b1;
                n_cnt                  = imu_bc_pkg::CNT_FIRST;
            end else begin
                o_ctl.lane.add  = 1'b1;
                o_ctl.use_accel = 1'b1;
                if (n_cnt == imu_bc_pkg::CNT_LAST) begin
                    o_ctl.flags.load_accel = 1'b1;
                    o_ctl.flags.accel_done = 1'b1;
                    n_accel_act            = 1'b0;
                    n_cnt                  = '0;
                end else begin
                    n_cnt = n_cnt + imu_bc_pkg::CNT_FIRST;
                end
            end
        end

        o_ctl.flags.busy = n_gyro_act || n_accel_act;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_act  <= 1'b0;
            r_accel_act <= 1'b0;
            r_cnt       <= '0;
        end else if (i_accept) begin
            r_gyro_act  <= n_gyro_act;
            r_accel_act <= n_accel_act;
            r_cnt       <= n_cnt;
        end
    end

endmodule

// ----- hdl/imu_bc_sum_lane.sv -----
// One accumulation lane: running sum, final-sum capture, mean by reciprocal multiply.
`timescale 1ns / 1ps

module imu_bc_sum_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_ld_in,
    input  logic                  i_ld_mid,
    input  imu_bc_pkg::t_lane_ctl i_ctl,
    input  logic signed [16:0]    i_val,
    output logic [15:0]           o_mean
);

    logic signed [imu_bc_pkg::SUM_W-1:0] r_sum;
    logic signed [imu_bc_pkg::SUM_W-1:0] r_fin;
    logic signed [imu_bc_pkg::SUM_W-1:0] n_acc;
    logic signed [imu_bc_pkg::SUM_W-1:0] n_sum;
    logic [imu_bc_pkg::SUM_W-1:0]        fin_abs;
    logic [imu_bc_pkg::MAG_W-1:0]        mag;
    logic [imu_bc_pkg::PROD_W-1:0]       prod;
    logic [15:0]                         r_q;
    logic                                r_neg;

    assign n_acc = r_sum + {{(imu_bc_pkg::SUM_W - 17){i_val[16]}}, i_val};

    always_comb begin
        priority if (i_ctl.clear) begin
            n_sum = '0;
        end else if (i_ctl.add) begin
            n_sum = n_acc;
        end else begin
            n_sum = r_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ld_in) begin
            r_sum <= n_sum;
        end
    end

    // sum including this item, used only by the item that ends a run
    always_ff @(posedge i_clk) begin
        if (i_ld_in) begin
            r_fin <= n_acc;
        end
    end

    // truncate toward zero: divide the magnitude, restore the sign after
    assign fin_abs = r_fin[imu_bc_pkg::SUM_W-1] ? (imu_bc_pkg::SUM_W'(0) - r_fin) : r_fin;
    assign mag     = fin_abs[imu_bc_pkg::MAG_W-1:0];
    assign prod    = imu_bc_pkg::PROD_W'(mag) * imu_bc_pkg::PROD_W'(imu_bc_pkg::RECIP);

    always_ff @(posedge i_clk) begin
        if (i_ld_mid) begin
            r_q   <= prod[imu_bc_pkg::DIV_SHIFT +: 16];
            r_neg <= r_fin[imu_bc_pkg::SUM_W-1];
        end
    end

    assign o_mean = r_neg ? (16'd0 - r_q) : r_q;

endmodule

// ----- hdl/imu_bc_corr_lane.sv -----
// One axis lane: offset register and wrapped subtraction with wrap detect.
`timescale 1ns / 1ps

module imu_bc_corr_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_ld,
    input  logic [15:0]          i_raw,
    input  imu_bc_pkg::t_off_ctl i_off,
    input  logic [15:0]          i_mean,
    output logic [15:0]          o_corr,
    output logic                 o_wrap
);

    logic [15:0] r_off;
    logic [15:0] r_corr;
    logic        r_wrap;
    logic [16:0] diff;

    assign diff = {i_raw[15], i_raw} - {r_off[15], r_off};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= '0;
        end else if (i_ld) begin
            priority if (i_off.zero) begin
                r_off <= '0;
            end else if (i_off.load) begin
                r_off <= i_mean;
            end
        end
    end

    // correction uses the offset held before this item's update
    always_ff @(posedge i_clk) begin
        if (i_ld) begin
            r_corr <= diff[15:0];
            r_wrap <= diff[16] ^ diff[15];
        end
    end

    assign o_corr = r_corr;
    assign o_wrap = r_wrap;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the IMU bias subtract / offset calibration block.
`timescale 1ns / 1ps

module tb;
    import imu_bc_pkg::*;

    localparam logic [14:0] ONE_G_RESET  = 15'd8196;
    localparam int          PRESSURE_AT  = 150;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          REPORT_LIMIT = 10;

    typedef logic [15:0] t_fields [10];

    // Predicts corrected samples and calibration flags, then checks them in order.
    class imu_bias_scoreboard;
        logic [14:0]        one_g;
        logic signed [15:0] axis_offset [6];   // 0..2 accel, 3..5 gyro
        logic signed [15:0] corr [6];
        longint             cal_sums [3];
        int                 cal_count;
        bit                 gyro_active;
        bit                 accel_active;
        t_out_item          expected_corr [$];
        int                 fail_count;
        string              field_names [10];

        function new();
            one_g = ONE_G_RESET;
            foreach (axis_offset[i]) axis_offset[i] = '0;
            foreach (cal_sums[i]) cal_sums[i] = 0;
            cal_count    = 0;
            gyro_active  = 1'b0;
            accel_active = 1'b0;
            fail_count   = 0;
            field_names  = '{"accel_x_corr", "accel_y_corr", "accel_z_corr",
                             "gyro_x_corr", "gyro_y_corr", "gyro_z_corr",
                             "wrap_flag", "gyro_cal_done", "accel_cal_done", "cal_busy"};
        endfunction

        function void set_one_g(logic [14:0] v);
            one_g = v;
        endfunction

        function bit is_calibrating();
            return gyro_active || accel_active;
        endfunction

        function int pending();
            return expected_corr.size();
        endfunction

        function void log_failure(string msg);
            fail_count++;
            if (fail_count <= REPORT_LIMIT) $display("MISMATCH %s", msg);
        endfunction

        // One calibration step on lanes base..base+2; returns 1 when it completes.
        function bit cal_advance(int base, int zsub);
            longint quot;
            if (cal_count == 0) begin
                // first item of a pass is thrown away, offsets cleared
                for (int i = 0; i < 3; i++) begin
                    axis_offset[base + i] = '0;
                    cal_sums[i] = 0;
                end
                cal_count = 1;
                return 1'b0;
            end
            for (int i = 0; i < 3; i++) cal_sums[i] += longint'(corr[base + i]);
            cal_sums[2] -= zsub;
            cal_count++;
            if (cal_count >= SAMPLES_PER_CAL) begin
                for (int i = 0; i < 3; i++) begin
                    quot = cal_sums[i] / SAMPLES_PER_CAL;   // truncates toward zero
                    axis_offset[base + i] = quot[15:0];
                end
                cal_count = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_sample(t_in_item it);
            logic signed [15:0] raw [6];
            t_out_item          r;
            int                 d;
            bit                 wrapped;
            bit                 gdone;
            bit                 adone;
            raw = '{it.accel_x, it.accel_y, it.accel_z, it.gyro_x, it.gyro_y, it.gyro_z};
            wrapped = 1'b0;
            gdone   = 1'b0;
            adone   = 1'b0;
            for (int i = 0; i < 6; i++) begin
                d = int'(raw[i]) - int'(axis_offset[i]);
                if (d < -32768 || d > 32767) wrapped = 1'b1;
                corr[i] = d[15:0];
            end
            if (!gyro_active && !accel_active && it.mode != MODE_SAMPLE) begin
                if (it.mode == MODE_ACCEL) accel_active = 1'b1;
                else gyro_active = 1'b1;
                cal_count = 0;
            end
            if (gyro_active) begin
                if (cal_advance(3, 0)) begin
                    // gyro pass hands over to accel on the same item
                    gdone        = 1'b1;
                    gyro_active  = 1'b0;
                    accel_active = 1'b1;
                    cal_count    = 0;
                end
            end
            if (accel_active) begin
                if (cal_advance(0, int'(one_g))) begin
                    adone        = 1'b1;
                    accel_active = 1'b0;
                end
            end
            r.accel_x_corr   = corr[0];
            r.accel_y_corr   = corr[1];
            r.accel_z_corr   = corr[2];
            r.gyro_x_corr    = corr[3];
            r.gyro_y_corr    = corr[4];
            r.gyro_z_corr    = corr[5];
            r.wrap_flag      = wrapped;
            r.gyro_cal_done  = gdone;
            r.accel_cal_done = adone;
            r.cal_busy       = gyro_active || accel_active;
            expected_corr.push_back(r);
        endfunction

        function t_fields field_values(t_out_item r);
            return '{r.accel_x_corr, r.accel_y_corr, r.accel_z_corr,
                     r.gyro_x_corr, r.gyro_y_corr, r.gyro_z_corr,
                     16'(r.wrap_flag), 16'(r.gyro_cal_done),
                     16'(r.accel_cal_done), 16'(r.cal_busy)};
        endfunction

        function void check_corrected(t_out_item got);
            t_out_item want;
            t_fields   w;
            t_fields   g;
            if (expected_corr.size() == 0) begin
                log_failure($sformatf("corrected sample %h with nothing outstanding", got));
                return;
            end
            want = expected_corr.pop_front();
            w = field_values(want);
            g = field_values(got);
            for (int i = 0; i < 10; i++) begin
                if (w[i] !== g[i])
                    log_failure($sformatf("%s: expected %0d, got %0d",
                                          field_names[i], $signed(w[i]), $signed(g[i])));
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [14:0] cfg_wr_data;
    int          sent_cnt;
    bit          quiet;

    imu_bias_scoreboard sb;

    imu_bc_in_if  in_ch ();
    imu_bc_out_if out_ch ();

    imu_bias_calibrate_subtract_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .o_out         (out_ch),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Transfers on both channels, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (in_ch.valid && in_ch.ready) sb.note_sample(in_ch.data);
            if (out_ch.valid && out_ch.ready) sb.check_corrected(out_ch.data);
        end
    end

    // Receiver: random stall bursts, plus one long hold-off to back up the pipeline.
    initial begin
        int hold;
        bit pressed;
        hold    = 0;
        pressed = 1'b0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (!pressed && sent_cnt >= PRESSURE_AT) begin
                pressed = 1'b1;
                hold    = HOLD_CYCLES;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                hold = $urandom_range(1, 11);
            end
            out_ch.ready <= (hold == 0);
        end
    end

    function automatic t_in_item build_item(logic [1:0] mode, t_axes ax);
        t_in_item it;
        it.mode    = mode;
        it.accel_x = ax[0];
        it.accel_y = ax[1];
        it.accel_z = ax[2];
        it.gyro_x  = ax[3];
        it.gyro_y  = ax[4];
        it.gyro_z  = ax[5];
        return it;
    endfunction

    function automatic t_in_item uniform_item(logic [1:0] mode, logic [15:0] v);
        return build_item(mode, {6{v}});
    endfunction

    // Full-range value, leaning on the extremes now and then.
    function automatic logic [15:0] any16();
        case ($urandom_range(0, 7))
            0: begin
                return 16'h8000;
            end
            1: begin
                return 16'h7FFF;
            end
            2: begin
                return 16'h0000;
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    function automatic t_axes near(t_axes c, int spread);
        t_axes r;
        int    v;
        for (int i = 0; i < 6; i++) begin
            v = int'($signed(c[i])) + int'($urandom_range(0, 2 * spread)) - spread;
            r[i] = v[15:0];
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input t_in_item it);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every corrected sample is back.
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending() > 0) @(negedge i_clk);
    endtask

    task automatic write_one_g(input logic [14:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        sb.set_one_g(v);
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Runs a calibration to completion with samples clustered around random centers.
    // req of MODE_SAMPLE just feeds one that is already running.
    task automatic calibrate(input logic [1:0] req, input bit extreme);
        t_axes    center;
        int       spread;
        t_in_item it;
        spread = extreme ? 0 : $urandom_range(0, 3000);
        for (int i = 0; i < 6; i++) begin
            if (extreme) center[i] = (i < 3) ? 16'h8000 : 16'h7FFF;
            else center[i] = any16();
        end
        if (req != MODE_SAMPLE) send_item(build_item(req, near(center, spread)));
        while (sb.is_calibrating()) begin
            it = build_item(MODE_SAMPLE, near(center, spread));
            if ($urandom_range(0, 15) == 0) it.mode = 2'($urandom_range(1, 3));
            send_item(it);
        end
    endtask

    task automatic noise_burst(input int n);
        t_axes    ax;
        t_in_item it;
        repeat (n) begin
            for (int i = 0; i < 6; i++) ax[i] = any16();
            it = build_item(MODE_SAMPLE, ax);
            // stray request: starts a calibration that gets fed with noise
            if ($urandom_range(0, 19) == 0) it.mode = 2'($urandom_range(1, 3));
            send_item(it);
        end
    endtask

    initial begin
        sb          = new();
        i_rst_n     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        sent_cnt    = 0;
        quiet       = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // field extremes with zero offsets
        send_item(uniform_item(MODE_SAMPLE, 16'h0000));
        send_item(uniform_item(MODE_SAMPLE, 16'h7FFF));
        send_item(uniform_item(MODE_SAMPLE, 16'h8000));
        send_item(uniform_item(MODE_SAMPLE, 16'hFFFF));
        send_item(build_item(MODE_SAMPLE, {3{16'h5555, 16'hAAAA}}));
        send_item(build_item(MODE_SAMPLE, {3{16'hAAAA, 16'h5555}}));
        // gyro request: discarded item, still corrected with the old offsets
        send_item(uniform_item(MODE_GYRO, 16'h1234));
        // requests while busy are ignored
        send_item(uniform_item(MODE_ACCEL, 16'h7FFF));
        send_item(uniform_item(MODE_BOTH, 16'h7FFF));
        send_item(uniform_item(MODE_GYRO, 16'h7FFF));
        // finish gyro, then the chained accel pass; accel Z mean wraps when stored
        calibrate(MODE_SAMPLE, 1'b1);
        noise_burst(20);
        drain();

        write_one_g(15'h7FFF);
        calibrate(MODE_ACCEL, 1'b0);
        noise_burst(50);
        drain();

        write_one_g(15'($urandom_range(0, 32767)));
        // closing stretch runs without idle cycles
        quiet = 1'b1;
        noise_burst(60);
        drain();

        repeat (8) @(negedge i_clk);
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/imu_bc_pkg.sv
hdl/imu_bc_in_if.sv
hdl/imu_bc_out_if.sv
hdl/imu_bc_ctrl.sv
hdl/imu_bc_sum_lane.sv
hdl/imu_bc_corr_lane.sv
hdl/imu_bias_calibrate_subtract_top.sv
tb/tb.sv
